// ===== rtl/core/mts_pkg.sv =====
package mts_pkg;

	localparam logic [1:0] ACT_PUSH  = 2'd0;
	localparam logic [1:0] ACT_POP   = 2'd1;
	localparam logic [1:0] ACT_QUERY = 2'd2;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

endpackage

// ===== rtl/core/mts_ram.sv =====
module mts_ram #(
	parameter int Depth = 64,
	parameter int Width = 34,
	localparam int AddrW = $clog2(Depth)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AddrW-1:0] wr_addr,
	input  logic [Width-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AddrW-1:0] rd_addr,
	output logic [Width-1:0] rd_data
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/core/min_tracking_stack.sv =====
// Signed stack that reports its minimum in constant time. A single minimum
// register is kept, and a value pushed below the minimum is stored in encoded
// form as twice the value minus the old minimum, so that the old minimum can be
// recovered when that entry is popped; entries are therefore two bits wider
// than the values. Every transaction returns one result with the status, the
// popped value, the decoded top, the minimum and the entry count. Push and
// query results are registered straight from the idle state. A pop that
// leaves the stack nonempty passes through the ST_POP state, because the
// new top entry is read from the entry memory, whose read data is registered;
// the top entry itself is held in a register. No clearing pass runs after reset.
module min_tracking_stack #(
	parameter int STACK_DEPTH = 64,
	parameter int VALUE_WIDTH = 32,
	localparam int CntW = $clog2(STACK_DEPTH + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    action,
	input  logic signed [VALUE_WIDTH-1:0] push_value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    status,
	output logic signed [VALUE_WIDTH-1:0] removed_value,
	output logic signed [VALUE_WIDTH-1:0] top_value,
	output logic signed [VALUE_WIDTH-1:0] min_value,
	output logic [CntW-1:0]               entry_count
);

	import mts_pkg::*;

	localparam int EntryW = VALUE_WIDTH + 2;
	localparam int AddrW = $clog2(STACK_DEPTH);

	typedef enum logic {
		ST_IDLE,
		ST_POP
	} state_t;

	state_t                    state_q;
	logic [CntW-1:0]           count_q;
	logic [VALUE_WIDTH-1:0]    min_q;
	logic [EntryW-1:0]         top_q;
	logic                      out_valid_q;
	logic [1:0]                status_q;
	logic [VALUE_WIDTH-1:0]    removed_q;
	logic [VALUE_WIDTH-1:0]    top_out_q;
	logic [VALUE_WIDTH-1:0]    min_out_q;
	logic [CntW-1:0]           count_out_q;

	logic                      accept;
	logic                      empty;
	logic                      full;
	logic [CntW-1:0]           count_m2;
	logic signed [EntryW-1:0]  x_ext;
	logic signed [EntryW-1:0]  min_ext;
	logic signed [EntryW-1:0]  top_ent;
	logic                      push_below;
	logic [EntryW-1:0]         push_entry;
	logic [VALUE_WIDTH-1:0]    push_min;
	logic                      pop_below;
	logic signed [EntryW-1:0]  pop_prev;
	logic [VALUE_WIDTH-1:0]    pop_removed;
	logic [VALUE_WIDTH-1:0]    pop_min;
	logic [VALUE_WIDTH-1:0]    cur_top;
	logic [VALUE_WIDTH-1:0]    push_top;
	logic [VALUE_WIDTH-1:0]    rd_top;
	logic                      wr_en;
	logic                      rd_en;
	logic [EntryW-1:0]         rd_data;

	// An entry that reads below the minimum stands for the minimum itself.
	function automatic logic [VALUE_WIDTH-1:0] decode_entry(
		input logic [EntryW-1:0] ent,
		input logic [VALUE_WIDTH-1:0] minv
	);
		logic signed [EntryW-1:0] e;
		logic signed [EntryW-1:0] m;
		e = ent;
		m = {{2{minv[VALUE_WIDTH-1]}}, minv};
		return (e < m) ? minv : ent[VALUE_WIDTH-1:0];
	endfunction

	assign in_stall = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign accept = in_valid && !in_stall;
	assign empty = (count_q == '0);
	assign full = (count_q == CntW'(STACK_DEPTH));
	assign count_m2 = count_q - CntW'(2);

	always_comb begin
		x_ext = {{2{push_value[VALUE_WIDTH-1]}}, push_value};
		min_ext = {{2{min_q[VALUE_WIDTH-1]}}, min_q};
		top_ent = top_q;
		push_below = (x_ext < min_ext);
		if (empty) begin
			push_entry = x_ext;
			push_min = push_value;
		end else if (push_below) begin
			push_entry = (x_ext <<< 1) - min_ext;
			push_min = push_value;
		end else begin
			push_entry = x_ext;
			push_min = min_q;
		end
		pop_below = (top_ent < min_ext);
		pop_prev = (min_ext <<< 1) - top_ent;
		pop_removed = pop_below ? min_q : top_q[VALUE_WIDTH-1:0];
		pop_min = pop_below ? pop_prev[VALUE_WIDTH-1:0] : min_q;
		cur_top = decode_entry(top_q, min_q);
		push_top = decode_entry(push_entry, push_min);
		rd_top = decode_entry(rd_data, min_q);
	end

	assign wr_en = accept && (action == ACT_PUSH) && !full;
	assign rd_en = accept && (action == ACT_POP) && (count_q > CntW'(1));

	mts_ram #(
		.Depth(STACK_DEPTH),
		.Width(EntryW)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(count_q[AddrW-1:0]),
		.wr_data(push_entry),
		.rd_en  (rd_en),
		.rd_addr(count_m2[AddrW-1:0]),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			min_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (action == ACT_PUSH) begin
							out_valid_q <= 1'b1;
							removed_q <= '0;
							if (full) begin
								status_q <= STATUS_FULL;
								top_out_q <= cur_top;
								min_out_q <= min_q;
								count_out_q <= count_q;
							end else begin
								status_q <= STATUS_OK;
								top_q <= push_entry;
								min_q <= push_min;
								count_q <= count_q + CntW'(1);
								top_out_q <= push_top;
								min_out_q <= push_min;
								count_out_q <= count_q + CntW'(1);
							end
						end else if (action == ACT_POP) begin
							if (empty) begin
								out_valid_q <= 1'b1;
								status_q <= STATUS_EMPTY;
								removed_q <= '0;
								top_out_q <= '0;
								min_out_q <= '0;
								count_out_q <= '0;
							end else begin
								status_q <= STATUS_OK;
								removed_q <= pop_removed;
								count_q <= count_q - CntW'(1);
								if (count_q == CntW'(1)) begin
									out_valid_q <= 1'b1;
									min_q <= '0;
									top_out_q <= '0;
									min_out_q <= '0;
									count_out_q <= '0;
								end else begin
									out_valid_q <= 1'b0;
									min_q <= pop_min;
									state_q <= ST_POP;
								end
							end
						end else begin
							out_valid_q <= 1'b1;
							removed_q <= '0;
							if (empty) begin
								status_q <= STATUS_EMPTY;
								top_out_q <= '0;
								min_out_q <= '0;
							end else begin
								status_q <= STATUS_OK;
								top_out_q <= cur_top;
								min_out_q <= min_q;
							end
							count_out_q <= count_q;
						end
					end else if (out_valid_q && !out_stall) begin
						out_valid_q <= 1'b0;
					end
				end
				ST_POP: begin
					top_q <= rd_data;
					top_out_q <= rd_top;
					min_out_q <= min_q;
					count_out_q <= count_q;
					out_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign removed_value = removed_q;
	assign top_value = top_out_q;
	assign min_value = min_out_q;
	assign entry_count = count_out_q;

endmodule

// ===== sim/min_tracking_stack_checker.sv =====
module min_tracking_stack_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [1:0]         action,
	input  logic signed [31:0] push_value,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [1:0]         status,
	input  logic signed [31:0] removed_value,
	input  logic signed [31:0] top_value,
	input  logic signed [31:0] min_value,
	input  logic [6:0]         entry_count,
	output int                 mismatch_count,
	output int                 results_waiting
);
	timeunit 1ns;
	timeprecision 1ps;

	import mts_pkg::*;

	localparam int DEPTH = 64;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] removed;
		logic [31:0] top;
		logic [31:0] minimum;
		logic [6:0]  count;
	} stack_result_t;

	logic signed [33:0] entry_mem [DEPTH];
	int                 held;
	logic signed [31:0] running_min;
	stack_result_t      expected_results [$];

	function automatic stack_result_t apply_stack_op(input logic [1:0] act,
			input logic signed [31:0] x);
		logic signed [33:0] x_ext;
		logic signed [33:0] min_ext;
		logic signed [33:0] ent;
		logic signed [33:0] restored;
		stack_result_t r;
		r = '0;
		x_ext = {{2{x[31]}}, x};
		min_ext = {{2{running_min[31]}}, running_min};
		if (act == ACT_PUSH) begin
			if (held >= DEPTH) begin
				r.status = STATUS_FULL;
			end else if (held == 0) begin
				running_min = x;
				entry_mem[0] = x_ext;
				held = 1;
			end else begin
				// A new minimum is stored encoded so the old one can be recovered.
				if (x < running_min) begin
					ent = 2 * x_ext - min_ext;
					running_min = x;
				end else begin
					ent = x_ext;
				end
				entry_mem[held] = ent;
				held++;
			end
		end else if (act == ACT_POP) begin
			if (held == 0) begin
				r.status = STATUS_EMPTY;
			end else begin
				ent = entry_mem[held-1];
				held--;
				if (ent < min_ext) begin
					r.removed = running_min;
					restored = 2 * min_ext - ent;
					running_min = restored[31:0];
				end else begin
					r.removed = ent[31:0];
				end
				if (held == 0)
					running_min = '0;
			end
		end else if (held == 0) begin
			r.status = STATUS_EMPTY;
		end
		if (held > 0) begin
			min_ext = {{2{running_min[31]}}, running_min};
			ent = entry_mem[held-1];
			r.top = (ent < min_ext) ? running_min : ent[31:0];
			r.minimum = running_min;
		end
		r.count = held[6:0];
		return r;
	endfunction

	task automatic check_field(input string field, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (want_v !== got_v) begin
			$display("%0t: %s expected 0x%h actual 0x%h", $time, field, want_v, got_v);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		stack_result_t want;
		if (!arst_n) begin
			held = 0;
			running_min = '0;
			expected_results.delete();
			results_waiting = 0;
		end else begin
			if (in_valid && !in_stall)
				expected_results.push_back(apply_stack_op(action, push_value));
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result with no transaction pending, status 0x%h count %0d",
						$time, status, entry_count);
					mismatch_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("status", 32'(want.status), 32'(status));
					check_field("removed_value", want.removed, removed_value);
					check_field("top_value", want.top, top_value);
					check_field("min_value", want.minimum, min_value);
					check_field("entry_count", 32'(want.count), 32'(entry_count));
				end
			end
			results_waiting = expected_results.size();
		end
	end

endmodule

// ===== sim/tb_min_tracking_stack.sv =====
module tb_min_tracking_stack;
	timeunit 1ns;
	timeprecision 1ps;

	import mts_pkg::*;

	localparam logic [1:0]  ACT_UNUSED = 2'd3;
	localparam int          DEPTH      = 64;
	localparam int          ITEM_GOAL  = 1450;
	localparam int          CYCLE_CAP  = 400000;
	localparam logic [31:0] VAL_MAX    = 32'h7FFF_FFFF;
	localparam logic [31:0] VAL_MIN    = 32'h8000_0000;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         action;
	logic signed [31:0] push_value;
	logic               out_valid;
	logic               out_stall;
	logic [1:0]         status;
	logic signed [31:0] removed_value;
	logic signed [31:0] top_value;
	logic signed [31:0] min_value;
	logic [6:0]         entry_count;
	int                 mismatch_count;
	int                 results_waiting;

	int cycle_count;
	int sent;
	int shadow_depth;
	int burst_left;

	min_tracking_stack dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.push_value   (push_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.removed_value(removed_value),
		.top_value    (top_value),
		.min_value    (min_value),
		.entry_count  (entry_count)
	);

	min_tracking_stack_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.action         (action),
		.push_value     (push_value),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.removed_value  (removed_value),
		.top_value      (top_value),
		.min_value      (min_value),
		.entry_count    (entry_count),
		.mismatch_count (mismatch_count),
		.results_waiting(results_waiting)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_CAP) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic send_op(input logic [1:0] act, input logic [31:0] val);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		action <= act;
		push_value <= val;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		sent++;
		if (act == ACT_PUSH && shadow_depth < DEPTH)
			shadow_depth++;
		else if (act == ACT_POP && shadow_depth > 0)
			shadow_depth--;
	endtask

	function automatic logic [31:0] pick_value(input int style);
		int sel;
		sel = (style == 3) ? $urandom_range(0, 2) : style;
		case (sel)
			0: return $urandom;
			1: return 32'($urandom_range(0, 16)) - 32'd8;
			default: begin
				case ($urandom_range(0, 4))
					0: return VAL_MAX;
					1: return VAL_MIN;
					2: return 32'd0;
					3: return 32'hFFFF_FFFF;
					default: return $urandom;
				endcase
			end
		endcase
	endfunction

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_QUERY;
		push_value = '0;
		out_stall = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin : receiver
		int seg_len;
		int mode;
		int seg_idx;
		@(posedge arst_n);
		seg_idx = 0;
		forever begin
			// One long hold-off early on so that a result waits in the output register and the block stalls its input.
			if (seg_idx == 4) begin
				out_stall <= 1'b1;
				repeat (300) @(posedge clk);
			end
			mode = $urandom_range(0, 2);
			seg_len = $urandom_range(20, 200);
			repeat (seg_len) begin
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					default: out_stall <= ($urandom_range(0, 3) != 0);
				endcase
				@(posedge clk);
			end
			seg_idx++;
		end
	end

	initial begin : stimulus
		int kind;
		int style;
		int run_len;
		int r;
		logic [31:0] val;
		sent = 0;
		shadow_depth = 0;
		burst_left = 0;
		@(posedge arst_n);
		@(posedge clk);

		send_op(ACT_QUERY, 32'd0);
		send_op(ACT_POP, 32'd0);
		send_op(ACT_UNUSED, 32'd0);
		send_op(ACT_PUSH, 32'd5);
		send_op(ACT_POP, 32'd0);
		send_op(ACT_PUSH, VAL_MAX);
		send_op(ACT_PUSH, VAL_MIN);
		send_op(ACT_PUSH, 32'hFFFF_FFFF);
		send_op(ACT_PUSH, VAL_MIN);
		send_op(ACT_QUERY, 32'd0);
		send_op(ACT_UNUSED, 32'hFFFF_FFFF);
		send_op(ACT_POP, 32'd0);
		send_op(ACT_POP, 32'd0);
		send_op(ACT_POP, 32'd0);
		send_op(ACT_QUERY, 32'd0);
		send_op(ACT_PUSH, 32'd0);
		send_op(ACT_PUSH, VAL_MIN);
		send_op(ACT_POP, 32'd0);
		send_op(ACT_POP, 32'd0);
		send_op(ACT_POP, 32'd0);
		send_op(ACT_PUSH, VAL_MIN);
		send_op(ACT_PUSH, VAL_MAX);
		send_op(ACT_POP, 32'd0);
		send_op(ACT_POP, 32'd0);

		while (sent < ITEM_GOAL) begin
			kind = $urandom_range(0, 9);
			style = $urandom_range(0, 3);
			if (kind <= 1) begin
				while (shadow_depth < DEPTH)
					send_op(ACT_PUSH, pick_value(style));
				repeat ($urandom_range(1, 4))
					send_op(ACT_PUSH, pick_value(style));
				send_op(ACT_QUERY, $urandom);
			end else if (kind <= 3) begin
				while (shadow_depth > 0)
					send_op(($urandom_range(0, 5) == 0) ? ACT_QUERY : ACT_POP, $urandom);
				repeat ($urandom_range(1, 3))
					send_op(($urandom_range(0, 1) == 0) ? ACT_POP : ACT_QUERY, $urandom);
			end else if (kind <= 8) begin
				run_len = $urandom_range(10, 40);
				repeat (run_len) begin
					r = $urandom_range(0, 19);
					if (r < 9)
						send_op(ACT_PUSH, pick_value(style));
					else if (r < 17)
						send_op(ACT_POP, $urandom);
					else if (r < 19)
						send_op(ACT_QUERY, $urandom);
					else
						send_op(ACT_UNUSED, $urandom);
				end
			end else begin
				run_len = $urandom_range(5, 20);
				val = pick_value(style);
				repeat (run_len) begin
					send_op(ACT_PUSH, val);
					val = val - 32'($urandom_range(1, 1000));
				end
				repeat (run_len)
					send_op(ACT_POP, $urandom);
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (results_waiting != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
